### src/jkvl_pkg.sv
// Shared constants, parse phase codes, status codes and a whitespace helper for the key/value locator.
package jkvl_pkg;

    localparam longint MAX_MESSAGE_BYTES = 65536;
    localparam int     MAX_DEPTH         = 255;
    localparam int     KEY_MAX_BYTES     = 8;

    localparam int OFFSET_W = $clog2(MAX_MESSAGE_BYTES) + 1;
    localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
    localparam int POS_W    = 16;
    localparam int KIDX_W   = 4;
    localparam int KEY_W    = 64;
    localparam int PHASE_W  = 4;
    localparam int STATUS_W = 2;

    localparam logic [PHASE_W-1:0] PH_BEFORE_OBJECT = 4'd0;
    localparam logic [PHASE_W-1:0] PH_EXPECT_KEY    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_IN_KEY        = 4'd2;
    localparam logic [PHASE_W-1:0] PH_AFTER_KEY     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BEFORE_VALUE  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_VALUE_STRING  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_VALUE_SCAN    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_AFTER_VALUE   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DONE          = 4'd8;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DEPTH     = 2'd3;

    localparam logic CFG_KEY_BYTES  = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

endpackage

### src/json_object_key_value_locator_unit.sv
// Dataflow: a byte is registered on transfer and parsed from that input register; the result of a
// last-marked byte goes from the input register through the parser into the output register.
// Throughput: one byte per cycle, except that a result that is not taken stalls the input
// only when another last-marked byte reaches the parser.
// Reset: synchronous, active low; clears the parser, the key registers and both valid flags.
module json_object_key_value_locator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [jkvl_pkg::KEY_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_is_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [jkvl_pkg::STATUS_W-1:0] o_status,
    output logic [jkvl_pkg::POS_W-1:0]    o_value_start,
    output logic [jkvl_pkg::POS_W-1:0]    o_value_stop
);
    import jkvl_pkg::*;

    logic [KEY_W-1:0]    r_key_bytes;
    logic [KIDX_W-1:0]   r_key_length;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;

    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic                r_in_str, n_in_str;
    logic                r_esc, n_esc;
    logic [KIDX_W-1:0]   r_key_index, n_key_index;
    logic                r_ksm, n_ksm;
    logic                r_match, n_match;
    logic [POS_W-1:0]    r_found_start, n_found_start;
    logic [POS_W-1:0]    r_found_end, n_found_end;
    logic [7:0]          r_lnb, n_lnb;
    logic [STATUS_W-1:0] r_error, n_error;
    logic [POS_W-1:0]    r_vbegin, n_vbegin;
    logic [POS_W-1:0]    r_vlast, n_vlast;
    logic                r_overlength, n_overlength;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [POS_W-1:0]    r_out_start, n_out_start;
    logic [POS_W-1:0]    r_out_end, n_out_end;

    logic                advance;
    logic                sp;
    logic [7:0]          b;
    logic [POS_W-1:0]    pos;
    logic                key_hit;
    logic [7:0]          key_byte;
    logic                do_scan;
    logic [DEPTH_W-1:0]  c_depth;
    logic                c_str;
    logic                c_esc;
    logic                skip_last;

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign b        = r_in_byte;
    assign sp       = is_space(r_in_byte);
    assign pos      = r_offset[POS_W-1:0];
    assign key_byte = r_key_bytes[{r_key_index[2:0], 3'b000} +: 8];
    assign key_hit  = (r_key_length <= KIDX_W'(KEY_MAX_BYTES)) && (r_key_index < r_key_length)
                      && (b == key_byte);

    always_comb begin
        n_phase       = r_phase;
        n_offset      = r_offset;
        n_depth       = r_depth;
        n_in_str      = r_in_str;
        n_esc         = r_esc;
        n_key_index   = r_key_index;
        n_ksm         = r_ksm;
        n_match       = r_match;
        n_found_start = r_found_start;
        n_found_end   = r_found_end;
        n_lnb         = r_lnb;
        n_error       = r_error;
        n_vbegin      = r_vbegin;
        n_vlast       = r_vlast;
        n_overlength  = r_overlength;
        do_scan       = 1'b0;
        c_depth       = r_depth;
        c_str         = r_in_str;
        c_esc         = r_esc;
        skip_last     = 1'b0;

        if (r_offset >= OFFSET_W'(MAX_MESSAGE_BYTES)) begin
            n_overlength = 1'b1;
        end else begin
            if (!sp) begin
                n_lnb = b;
            end
            n_offset = r_offset + OFFSET_W'(1);
            unique case (r_phase) inside
                PH_BEFORE_OBJECT: begin
                    if (!sp) begin
                        if (b == CH_LBRACE) begin
                            n_phase = PH_EXPECT_KEY;
                        end else begin
                            n_error = ST_MALFORMED;
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_EXPECT_KEY, PH_AFTER_VALUE: begin
                    if (!sp) begin
                        if (b == CH_COMMA && r_phase == PH_AFTER_VALUE) begin
                            n_phase = PH_EXPECT_KEY;
                        end else if (b == CH_RBRACE) begin
                            n_phase = PH_DONE;
                        end else if (b == CH_QUOTE) begin
                            n_phase     = PH_IN_KEY;
                            n_key_index = '0;
                            n_ksm       = 1'b1;
                            n_esc       = 1'b0;
                        end else begin
                            n_error = ST_MALFORMED;
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_IN_KEY: begin
                    if (r_esc || (b != CH_BACKSLASH && b != CH_QUOTE)) begin
                        n_esc = 1'b0;
                        if (key_hit) begin
                            n_key_index = r_key_index + KIDX_W'(1);
                        end else begin
                            n_ksm = 1'b0;
                        end
                    end else if (b == CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        n_ksm   = r_ksm && (r_key_index == r_key_length)
                                  && (r_key_length <= KIDX_W'(KEY_MAX_BYTES));
                        n_phase = PH_AFTER_KEY;
                    end
                end
                PH_AFTER_KEY: begin
                    if (!sp) begin
                        if (b == CH_COLON) begin
                            n_phase = PH_BEFORE_VALUE;
                        end else begin
                            n_error = ST_MALFORMED;
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_BEFORE_VALUE: begin
                    if (!sp) begin
                        n_vbegin = pos;
                        n_vlast  = pos - POS_W'(1);
                        n_depth  = '0;
                        n_in_str = 1'b0;
                        n_esc    = 1'b0;
                        c_depth  = '0;
                        c_str    = 1'b0;
                        c_esc    = 1'b0;
                        if (b == CH_QUOTE) begin
                            n_phase = PH_VALUE_STRING;
                        end else begin
                            n_phase = PH_VALUE_SCAN;
                            do_scan = 1'b1;
                        end
                    end
                end
                PH_VALUE_STRING: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (b == CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        if (r_ksm) begin
                            n_match       = 1'b1;
                            n_found_start = r_vbegin;
                            n_found_end   = pos;
                            n_phase       = PH_DONE;
                        end else begin
                            n_phase = PH_AFTER_VALUE;
                        end
                    end
                end
                PH_VALUE_SCAN: begin
                    do_scan = 1'b1;
                end
                default: begin
                end
            endcase

            if (do_scan) begin
                if (c_str) begin
                    if (c_esc) begin
                        n_esc = 1'b0;
                    end else if (b == CH_BACKSLASH) begin
                        n_esc = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        n_in_str = 1'b0;
                    end
                end else if (b == CH_QUOTE) begin
                    n_in_str = 1'b1;
                end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
                    if (c_depth >= DEPTH_W'(MAX_DEPTH)) begin
                        n_error   = ST_DEPTH;
                        n_phase   = PH_DONE;
                        skip_last = 1'b1;
                    end else begin
                        n_depth = c_depth + DEPTH_W'(1);
                    end
                end else if (b == CH_RBRACE || b == CH_RBRACKET
                             || (b == CH_COMMA && c_depth == '0)) begin
                    if (c_depth == '0) begin
                        skip_last = 1'b1;
                        if (r_ksm) begin
                            n_match       = 1'b1;
                            n_found_start = n_vbegin;
                            n_found_end   = n_vlast;
                            n_phase       = PH_DONE;
                        end else if (b == CH_COMMA) begin
                            n_phase = PH_EXPECT_KEY;
                        end else if (b == CH_RBRACE) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_error = ST_MALFORMED;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_depth = c_depth - DEPTH_W'(1);
                        if (n_depth == '0) begin
                            skip_last = 1'b1;
                            if (r_ksm) begin
                                n_match       = 1'b1;
                                n_found_start = n_vbegin;
                                n_found_end   = pos;
                                n_phase       = PH_DONE;
                            end else begin
                                n_phase = PH_AFTER_VALUE;
                            end
                        end
                    end
                end
                if (!skip_last && !sp) begin
                    n_vlast = pos;
                end
            end
        end
    end

    always_comb begin
        n_out_status = ST_NOT_FOUND;
        n_out_start  = '0;
        n_out_end    = '0;
        if (n_overlength || n_lnb != CH_RBRACE) begin
            n_out_status = ST_MALFORMED;
        end else if (n_match) begin
            n_out_status = ST_FOUND;
            n_out_start  = n_found_start;
            n_out_end    = n_found_end;
        end else if (n_error != ST_FOUND) begin
            n_out_status = n_error;
        end else if (n_phase == PH_VALUE_SCAN && n_ksm) begin
            n_out_status = ST_FOUND;
            n_out_start  = n_vbegin;
            n_out_end    = n_vlast;
        end else if (n_phase == PH_IN_KEY || n_phase == PH_AFTER_KEY
                     || n_phase == PH_BEFORE_VALUE || n_phase == PH_VALUE_STRING
                     || n_phase == PH_BEFORE_OBJECT) begin
            n_out_status = ST_MALFORMED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes  <= '0;
            r_key_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_BYTES:  r_key_bytes  <= i_cfg_data;
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data[KIDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_phase       <= PH_BEFORE_OBJECT;
            r_offset      <= '0;
            r_depth       <= '0;
            r_in_str      <= 1'b0;
            r_esc         <= 1'b0;
            r_key_index   <= '0;
            r_ksm         <= 1'b1;
            r_match       <= 1'b0;
            r_found_start <= '0;
            r_found_end   <= '0;
            r_lnb         <= '0;
            r_error       <= '0;
            r_vbegin      <= '0;
            r_vlast       <= '0;
            r_overlength  <= 1'b0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_offset      <= n_offset;
            r_depth       <= n_depth;
            r_in_str      <= n_in_str;
            r_esc         <= n_esc;
            r_key_index   <= n_key_index;
            r_ksm         <= n_ksm;
            r_match       <= n_match;
            r_found_start <= n_found_start;
            r_found_end   <= n_found_end;
            r_lnb         <= n_lnb;
            r_error       <= n_error;
            r_vbegin      <= n_vbegin;
            r_vlast       <= n_vlast;
            r_overlength  <= n_overlength;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_status <= n_out_status;
            r_out_start  <= n_out_start;
            r_out_end    <= n_out_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_value_start = r_out_start;
    assign o_value_stop  = r_out_end;

endmodule

### src/jkvl_checker.sv
// Port-level checker for the key/value locator and its bind to the top level.
module jkvl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [jkvl_pkg::STATUS_W-1:0] o_status,
    input logic [jkvl_pkg::POS_W-1:0]    o_value_start,
    input logic [jkvl_pkg::POS_W-1:0]    o_value_stop
);
    import jkvl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_value_start) && $stable(o_value_stop))
        else $error("result changed or dropped before transfer");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result register");

    a_range_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_FOUND |-> o_value_start == '0 && o_value_stop == '0)
        else $error("value range given without a match");

endmodule

bind json_object_key_value_locator_unit jkvl_checker u_jkvl_checker (.*);

### test/json_object_key_value_locator_unit_tb.sv
// Testbench for the JSON key/value locator: object byte streams checked against a built-in predictor.
module json_object_key_value_locator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jkvl_pkg::*;

    localparam logic [7:0] LETTER_A = 8'h61;
    localparam logic [7:0] DIGIT_0  = 8'h30;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    vstart;
        logic [POS_W-1:0]    vend;
    } t_locator_result;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = 1'b0;
    logic [KEY_W-1:0]    cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [7:0]          data_byte = '0;
    logic                is_last   = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    value_start;
    logic [POS_W-1:0]    value_stop;

    json_object_key_value_locator_unit DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_data_byte  (data_byte),
        .i_is_last    (is_last),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_value_start(value_start),
        .o_value_stop (value_stop)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;

    t_locator_result pending_results[$];
    t_locator_result want;
    logic [7:0]      byte_q[$];

    // predictor state
    logic [KEY_W-1:0]   cfg_key = '0;
    logic [3:0]         cfg_len = '0;
    logic [PHASE_W-1:0] ph;
    int                 offs;
    int                 depth;
    bit                 in_str;
    bit                 esc;
    int                 kidx;
    bit                 kmatch;
    bit                 hit;
    int                 hit_start;
    int                 hit_end;
    logic [7:0]         last_visible;
    bit                 parse_failed;
    logic [STATUS_W-1:0] err_code;
    int                 val_begin;
    int                 val_last;
    bit                 too_long;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void append_byte(logic [7:0] b);
        byte_q.insert(byte_q.size(), b);
    endfunction

    function automatic bit blank_char(logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic void clear_parser();
        ph = PH_BEFORE_OBJECT;
        offs = 0;
        depth = 0;
        in_str = 0;
        esc = 0;
        kidx = 0;
        kmatch = 1;
        hit = 0;
        hit_start = 0;
        hit_end = 0;
        last_visible = '0;
        parse_failed = 0;
        err_code = ST_FOUND;
        val_begin = 0;
        val_last = 0;
        too_long = 0;
    endfunction

    function automatic void abort_parse(logic [STATUS_W-1:0] code);
        parse_failed = 1;
        err_code = code;
        ph = PH_DONE;
    endfunction

    function automatic void take_key_char(logic [7:0] b);
        if (cfg_len <= KEY_MAX_BYTES && kidx < cfg_len && b == cfg_key[8*kidx +: 8])
            kidx++;
        else
            kmatch = 0;
    endfunction

    function automatic void open_key();
        ph = PH_IN_KEY;
        kidx = 0;
        kmatch = 1;
        esc = 0;
    endfunction

    function automatic bit close_value(int last_pos);
        if (kmatch) begin
            hit = 1;
            hit_start = val_begin;
            hit_end = last_pos;
            ph = PH_DONE;
            return 1;
        end
        return 0;
    endfunction

    function automatic void scan_value_byte(logic [7:0] b, int pos);
        if (in_str) begin
            if (esc) esc = 0;
            else if (b == CH_BACKSLASH) esc = 1;
            else if (b == CH_QUOTE) in_str = 0;
        end else if (b == CH_QUOTE) begin
            in_str = 1;
        end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
            if (depth >= MAX_DEPTH) begin
                abort_parse(ST_DEPTH);
                return;
            end
            depth++;
        end else if (b == CH_RBRACE || b == CH_RBRACKET || (b == CH_COMMA && depth == 0)) begin
            if (depth == 0) begin
                if (close_value(val_last)) return;
                if (b == CH_COMMA) ph = PH_EXPECT_KEY;
                else if (b == CH_RBRACE) ph = PH_DONE;
                else abort_parse(ST_MALFORMED);
                return;
            end
            depth--;
            if (depth == 0) begin
                if (!close_value(pos)) ph = PH_AFTER_VALUE;
                return;
            end
        end
        if (!blank_char(b)) val_last = pos;
    endfunction

    function automatic void parse_byte(logic [7:0] b, int pos);
        bit sp;
        sp = blank_char(b);
        case (ph)
            PH_BEFORE_OBJECT: begin
                if (!sp) begin
                    if (b == CH_LBRACE) ph = PH_EXPECT_KEY;
                    else abort_parse(ST_MALFORMED);
                end
            end
            PH_AFTER_VALUE: begin
                if (!sp) begin
                    if (b == CH_COMMA) ph = PH_EXPECT_KEY;
                    else if (b == CH_RBRACE) ph = PH_DONE;
                    else if (b == CH_QUOTE) open_key();
                    else abort_parse(ST_MALFORMED);
                end
            end
            PH_EXPECT_KEY: begin
                if (!sp) begin
                    if (b == CH_RBRACE) ph = PH_DONE;
                    else if (b == CH_QUOTE) open_key();
                    else abort_parse(ST_MALFORMED);
                end
            end
            PH_IN_KEY: begin
                if (esc) begin
                    esc = 0;
                    take_key_char(b);
                end else if (b == CH_BACKSLASH) begin
                    esc = 1;
                end else if (b == CH_QUOTE) begin
                    kmatch = kmatch && kidx == cfg_len && cfg_len <= KEY_MAX_BYTES;
                    ph = PH_AFTER_KEY;
                end else begin
                    take_key_char(b);
                end
            end
            PH_AFTER_KEY: begin
                if (!sp) begin
                    if (b == CH_COLON) ph = PH_BEFORE_VALUE;
                    else abort_parse(ST_MALFORMED);
                end
            end
            PH_BEFORE_VALUE: begin
                if (!sp) begin
                    val_begin = pos;
                    val_last = pos - 1;
                    depth = 0;
                    in_str = 0;
                    esc = 0;
                    if (b == CH_QUOTE) begin
                        ph = PH_VALUE_STRING;
                    end else begin
                        ph = PH_VALUE_SCAN;
                        scan_value_byte(b, pos);
                    end
                end
            end
            PH_VALUE_STRING: begin
                if (esc) esc = 0;
                else if (b == CH_BACKSLASH) esc = 1;
                else if (b == CH_QUOTE) begin
                    if (!close_value(pos)) ph = PH_AFTER_VALUE;
                end
            end
            PH_VALUE_SCAN: scan_value_byte(b, pos);
            default: ;
        endcase
    endfunction

    function automatic void locate_step(logic [7:0] b, logic last);
        t_locator_result r;
        r = '0;
        if (offs >= MAX_MESSAGE_BYTES) begin
            too_long = 1;
        end else begin
            if (!blank_char(b)) last_visible = b;
            parse_byte(b, offs);
            offs++;
        end
        if (!last) return;
        if (too_long || last_visible != CH_RBRACE) begin
            r.status = ST_MALFORMED;
        end else if (hit) begin
            r.status = ST_FOUND;
            r.vstart = hit_start[POS_W-1:0];
            r.vend = hit_end[POS_W-1:0];
        end else if (parse_failed) begin
            r.status = err_code;
        end else if (ph == PH_VALUE_SCAN && kmatch) begin
            r.status = ST_FOUND;
            r.vstart = val_begin[POS_W-1:0];
            r.vend = val_last[POS_W-1:0];
        end else if (ph == PH_IN_KEY || ph == PH_AFTER_KEY || ph == PH_BEFORE_VALUE
                     || ph == PH_VALUE_STRING || ph == PH_BEFORE_OBJECT) begin
            r.status = ST_MALFORMED;
        end else begin
            r.status = ST_NOT_FOUND;
        end
        pending_results.insert(pending_results.size(), r);
        clear_parser();
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with no expectation waiting");
            end else begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (value_start !== want.vstart)
                    report_mismatch($sformatf("value_start %0d, expected %0d",
                                              value_start, want.vstart));
                if (value_stop !== want.vend)
                    report_mismatch($sformatf("value stop %0d, expected %0d",
                                              value_stop, want.vend));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        is_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        locate_step(b, last);
    endtask

    task automatic send_object();
        for (int i = 0; i < byte_q.size(); i++)
            send_byte(byte_q[i], i == byte_q.size() - 1);
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    endfunction

    task automatic send_text(input string s);
        byte_q.delete();
        put_text(s);
        send_object();
    endtask

    task automatic wait_block_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_key(input logic [KEY_W-1:0] bytes, input logic [3:0] len);
        logic [KEY_W-1:0] len_word;
        wait_block_idle();
        len_word = {$urandom(), $urandom()};
        len_word[3:0] = len;
        cfg_we <= 1'b1;
        cfg_index <= CFG_KEY_BYTES;
        cfg_data <= bytes;
        @(posedge clk);
        cfg_key = bytes;
        cfg_index <= CFG_KEY_LENGTH;
        cfg_data <= len_word;
        @(posedge clk);
        cfg_len = len;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] key_from_text(string s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < KEY_MAX_BYTES; i++) k[8*i +: 8] = s[i];
        return k;
    endfunction

    function automatic void put_ws();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
        repeat (n) begin
            case ($urandom_range(5))
                0: append_byte(8'd32);
                1: append_byte(8'd9);
                2: append_byte(8'd10);
                3: append_byte(8'd13);
                4: append_byte(8'd11);
                default: append_byte(8'd12);
            endcase
        end
    endfunction

    function automatic void put_key_char(logic [7:0] c);
        if (c == CH_QUOTE || c == CH_BACKSLASH || $urandom_range(7) == 0)
            append_byte(CH_BACKSLASH);
        append_byte(c);
    endfunction

    function automatic void put_raw_key(logic [KEY_W-1:0] k, int n);
        append_byte(CH_QUOTE);
        for (int i = 0; i < n; i++) put_key_char(k[8*i +: 8]);
        append_byte(CH_QUOTE);
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(7))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_LBRACKET;
            3: return CH_RBRACKET;
            4: return CH_COMMA;
            5: return CH_COLON;
            6: return CH_QUOTE;
            default: return CH_BACKSLASH;
        endcase
    endfunction

    function automatic logic [7:0] key_symbol();
        case ($urandom_range(7))
            0: return 8'($urandom_range(255));
            1: return ($urandom_range(1) == 0) ? CH_QUOTE : CH_BACKSLASH;
            default: return LETTER_A + 8'($urandom_range(3));
        endcase
    endfunction

    function automatic void put_key();
        int n;
        int j;
        n = (cfg_len > KEY_MAX_BYTES) ? KEY_MAX_BYTES : cfg_len;
        append_byte(CH_QUOTE);
        case ($urandom_range(5))
            0, 1: for (int i = 0; i < n; i++) put_key_char(cfg_key[8*i +: 8]);
            2: for (int i = 0; i < n - 1; i++) put_key_char(cfg_key[8*i +: 8]);
            3: begin
                for (int i = 0; i < n; i++) put_key_char(cfg_key[8*i +: 8]);
                put_key_char(key_symbol());
            end
            4: begin
                j = (n > 0) ? $urandom_range(n - 1) : 0;
                for (int i = 0; i < n; i++)
                    put_key_char((i == j) ? cfg_key[8*i +: 8] ^ (8'd1 << $urandom_range(7))
                                          : cfg_key[8*i +: 8]);
            end
            default: repeat ($urandom_range(4)) put_key_char(LETTER_A + 8'($urandom_range(3)));
        endcase
        append_byte(CH_QUOTE);
    endfunction

    function automatic void put_string();
        logic [7:0] c;
        append_byte(CH_QUOTE);
        repeat ($urandom_range(5)) begin
            case ($urandom_range(4))
                0: begin
                    append_byte(CH_BACKSLASH);
                    append_byte(($urandom_range(1) == 0) ? CH_QUOTE : CH_BACKSLASH);
                end
                1: append_byte(pick_punct());
                2: begin
                    c = 8'($urandom_range(255));
                    if (c == CH_QUOTE || c == CH_BACKSLASH) c = LETTER_A;
                    append_byte(c);
                end
                default: append_byte(LETTER_A + 8'($urandom_range(3)));
            endcase
        end
        append_byte(CH_QUOTE);
    endfunction

    function automatic void put_value(int lvl);
        int n;
        case ($urandom_range((lvl < 2) ? 6 : 4))
            0, 1: put_string();
            2: begin
                if ($urandom_range(3) == 0) put_text("-");
                repeat ($urandom_range(4, 1)) append_byte(DIGIT_0 + 8'($urandom_range(9)));
            end
            3: begin
                case ($urandom_range(2))
                    0: put_text("true");
                    1: put_text("false");
                    default: put_text("null");
                endcase
            end
            4: ;
            5: begin
                append_byte(CH_LBRACKET);
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    put_ws();
                    put_value(lvl + 1);
                    if (i < n - 1) append_byte(CH_COMMA);
                end
                append_byte(CH_RBRACKET);
            end
            default: begin
                append_byte(CH_LBRACE);
                n = $urandom_range(2);
                for (int i = 0; i < n; i++) begin
                    put_string();
                    append_byte(CH_COLON);
                    put_value(lvl + 1);
                    if (i < n - 1) append_byte(CH_COMMA);
                end
                append_byte(CH_RBRACE);
            end
        endcase
    endfunction

    function automatic void put_object();
        int n;
        put_ws();
        append_byte(CH_LBRACE);
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) begin
            put_ws();
            put_key();
            put_ws();
            append_byte(CH_COLON);
            put_ws();
            put_value(0);
            put_ws();
            if (i < n - 1 && $urandom_range(7) != 0) append_byte(CH_COMMA);
        end
        put_ws();
        append_byte(CH_RBRACE);
        put_ws();
    endfunction

    function automatic void mangle_object();
        int k;
        case ($urandom_range(4))
            0: if (byte_q.size() > 1) byte_q.delete($urandom_range(byte_q.size() - 1));
            1: byte_q.insert($urandom_range(byte_q.size()), 8'($urandom_range(255)));
            2: byte_q[$urandom_range(byte_q.size() - 1)] = 8'($urandom_range(255));
            3: begin
                if (byte_q.size() > 1) begin
                    k = $urandom_range(byte_q.size() - 1, 1);
                    byte_q = byte_q[0:k-1];
                end
            end
            default: begin
                byte_q.delete();
                repeat ($urandom_range(12, 1)) append_byte(8'($urandom_range(255)));
            end
        endcase
        if (byte_q.size() == 0) append_byte(CH_RBRACE);
    endfunction

    task automatic load_random_key();
        logic [KEY_W-1:0] k;
        logic [3:0]       len;
        for (int i = 0; i < KEY_MAX_BYTES; i++) k[8*i +: 8] = key_symbol();
        case ($urandom_range(9))
            0: len = 4'd0;
            1: len = 4'(9 + $urandom_range(6));
            2: len = 4'd8;
            default: len = 4'($urandom_range(8, 1));
        endcase
        load_key(k, len);
    endtask

    task automatic test_frames_and_members();
        load_key(key_from_text("ab"), 4'd2);
        send_text("{\"ab\":123}");
        send_text(" \t{ \"x\" : \"s\\\"}\" , \"ab\" : [1,{\"c\":\"]\"}] }\n");
        send_text("{\"ab\":}");
        send_text("x{}");
        send_text("{\"ab\":1");
        send_text("   ");
        send_text("}");
        send_text("{\"x\":\"1\"\"ab\":2}");
        send_text("{}");
        send_text("{\"x\":1,}");
        send_text("{x:1}");
        send_text("{\"ab\" 1}");
        send_text("{\"x\":1]}");
        send_text("{\"ab}");
        send_text("{\"x\":\"abc}");
        send_text("{\"ab\":1,x}");
        send_text("{\"ab\":[[}");
        send_text("{\"\\a\\b\":null}");
        send_text("{\"ab\":\"v\\\\\"}");
        send_text("{\"abc\":1,\"a\":2,\"ab\" : 3 }");
    endtask

    task automatic test_key_extremes();
        load_key('0, 4'd0);
        send_text("{\"\":5}");
        send_text("{\"a\":1,\"\" :[2]}");
        load_key({8{8'hFF}}, 4'd8);
        byte_q.delete();
        put_text("{");
        put_raw_key({8{8'hFF}}, KEY_MAX_BYTES);
        put_text(":true}");
        send_object();
        load_key('0, 4'd8);
        byte_q.delete();
        put_text("{\"q\":0,");
        put_raw_key('0, KEY_MAX_BYTES);
        put_text(" : \"z\" }");
        send_object();
        load_key(key_from_text("abcdefgh"), 4'd9);
        send_text("{\"abcdefgh\":1}");
        load_key(key_from_text("abcdefgh"), 4'd15);
        send_text("{\"abcdefgh\":1}");
        load_key(key_from_text("abcdefgh"), 4'd8);
        send_text("{\"abcdefgh\":1}");
        send_text("{\"abcdefg\":1,\"abcdefghi\":2}");
    endtask

    task automatic test_nesting_depth();
        load_key(key_from_text("ab"), 4'd2);
        byte_q.delete();
        put_text("{\"ab\":");
        repeat (MAX_DEPTH) append_byte(CH_LBRACKET);
        repeat (MAX_DEPTH) append_byte(CH_RBRACKET);
        put_text("}");
        send_object();
        byte_q.delete();
        put_text("{\"ab\":");
        repeat (MAX_DEPTH + 1) append_byte(CH_LBRACKET);
        put_text("}");
        send_object();
    endtask

    task automatic test_random_objects(input int n_bytes);
        int sent;
        int count;
        sent = 0;
        count = 0;
        while (sent < n_bytes) begin
            if (count % 6 == 0) load_random_key();
            byte_q.delete();
            put_object();
            if ($urandom_range(4) == 0) mangle_object();
            sent += byte_q.size();
            send_object();
            count++;
        end
    endtask

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        clear_parser();
        send_idle_pct = 20;
        recv_idle_pct = 82;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_frames_and_members();
        test_random_objects(200);
        send_idle_pct = 82;
        recv_idle_pct = 20;
        test_key_extremes();
        test_nesting_depth();
        test_random_objects(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_objects(200);
        wait_block_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
